>>> sv/ttc_pkg.sv
// constants and helpers for the three-timer block with target compare
// no dependencies; imported by triple_timer_with_target_compare_top
package ttc_pkg;

  localparam int NumTimers = 3;
  localparam int CntW      = 16;
  localparam int ModeW     = 10;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  localparam int MODE_RST_TGT = 3;
  localparam int MODE_IRQ_TGT = 4;
  localparam int MODE_IRQ_WRP = 5;
  localparam int MODE_GATE    = 8;

  localparam logic [CntW-1:0] CNT_MAX = 16'hFFFF;

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ModeW-1:0] mode_t;

  // does the selected source of timer idx follow this tick kind
  function automatic logic src_match(input logic [1:0] idx, input logic [1:0] src,
                                     input logic [1:0] kind);
    logic hit;
    hit = (src == kind);
    unique case (idx)
      2'd0:    src_match = hit && (src == 2'd0 || src == 2'd1);
      2'd1:    src_match = hit && (src == 2'd0 || src == 2'd1 || src == 2'd2);
      2'd2:    src_match = hit && (src == 2'd0 || src == 2'd3);
      default: src_match = 1'b0;
    endcase
  endfunction

endpackage

>>> sv/triple_timer_with_target_compare_top.sv
// three 16-bit timers with target compare, sticky flags and irq mask
// depends on ttc_pkg
// result: registered, valid in the cycle after the input transfer
// throughput: one item per cycle; an item is taken whenever the result
//   register is empty or its result is taken in the same cycle
// reset: counters, modes, targets and flags go to zero, no result pending
module triple_timer_with_target_compare_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [1:0]           timer_sel,
  input  logic [1:0]           reg_sel,
  input  ttc_pkg::cnt_t        write_data,
  input  logic [1:0]           clock_kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttc_pkg::cnt_t        read_data,
  output logic [2:0]           irq_mask
);
  import ttc_pkg::*;

  cnt_t  count_value  [NumTimers];
  mode_t mode_bits    [NumTimers];
  cnt_t  target_value [NumTimers];
  logic  target_hit_flag [NumTimers];
  logic  wrap_hit_flag   [NumTimers];

  cnt_t  count_value_next  [NumTimers];
  mode_t mode_bits_next    [NumTimers];
  cnt_t  target_value_next [NumTimers];
  logic  target_hit_flag_next [NumTimers];
  logic  wrap_hit_flag_next   [NumTimers];

  cnt_t       read_data_next;
  logic [2:0] irq_mask_next;
  logic       in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    logic [1:0]   idx;
    logic         sel;
    logic [CntW:0] inc;
    logic         tgt_hit;
    logic         wrap_hit;
    mode_t        m;
    mode_t        wm;
    read_data_next = '0;
    irq_mask_next  = '0;
    for (int i = 0; i < NumTimers; i++) begin
      idx      = 2'(i);
      sel      = (timer_sel == idx);
      m        = mode_bits[i];
      wm       = write_data[ModeW-1:0];
      inc      = {1'b0, count_value[i]} + {{CntW{1'b0}}, 1'b1};
      tgt_hit  = m[MODE_RST_TGT] && (target_value[i] != '0) &&
                 (inc == {1'b0, target_value[i]});
      wrap_hit = (count_value[i] == CNT_MAX);
      count_value_next[i]     = count_value[i];
      mode_bits_next[i]       = m;
      target_value_next[i]    = target_value[i];
      target_hit_flag_next[i] = target_hit_flag[i];
      wrap_hit_flag_next[i]   = wrap_hit_flag[i];
      unique case (cmd)
        CMD_READ: begin
          if (sel) begin
            unique case (reg_sel)
              REG_COUNT:  read_data_next = count_value[i];
              REG_MODE: begin
                read_data_next = {3'b000, wrap_hit_flag[i], target_hit_flag[i],
                                  (target_hit_flag[i] && m[MODE_IRQ_TGT]) ||
                                  (wrap_hit_flag[i] && m[MODE_IRQ_WRP]), m};
                target_hit_flag_next[i] = 1'b0;
                wrap_hit_flag_next[i]   = 1'b0;
              end
              REG_TARGET: read_data_next = target_value[i];
              default: ;
            endcase
          end
        end
        CMD_WRITE: begin
          if (sel) begin
            unique case (reg_sel)
              REG_COUNT:  count_value_next[i] = write_data;
              REG_MODE: begin
                mode_bits_next[i]       = wm;
                count_value_next[i]     = '0;
                target_hit_flag_next[i] = 1'b0;
                wrap_hit_flag_next[i]   = 1'b0;
                irq_mask_next[i] = wm[MODE_GATE] && wm[MODE_IRQ_TGT] &&
                                   (target_value[i] == '0);
              end
              REG_TARGET: target_value_next[i] = write_data;
              default: ;
            endcase
          end
        end
        CMD_TICK: begin
          if (src_match(idx, m[9:8], clock_kind)) begin
            if (tgt_hit) begin
              target_hit_flag_next[i] = 1'b1;
              count_value_next[i]     = '0;
              irq_mask_next[i]        = m[MODE_IRQ_TGT] && m[MODE_GATE];
            end else if (wrap_hit) begin
              wrap_hit_flag_next[i]   = 1'b1;
              count_value_next[i]     = '0;
              irq_mask_next[i]        = m[MODE_IRQ_WRP] && m[MODE_GATE];
            end else begin
              count_value_next[i]     = inc[CntW-1:0];
            end
          end
        end
        CMD_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        count_value[i]     <= '0;
        mode_bits[i]       <= '0;
        target_value[i]    <= '0;
        target_hit_flag[i] <= 1'b0;
        wrap_hit_flag[i]   <= 1'b0;
      end
    end else begin
      if (in_fire) begin
        out_valid <= 1'b1;
        for (int i = 0; i < NumTimers; i++) begin
          count_value[i]     <= count_value_next[i];
          mode_bits[i]       <= mode_bits_next[i];
          target_value[i]    <= target_value_next[i];
          target_hit_flag[i] <= target_hit_flag_next[i];
          wrap_hit_flag[i]   <= wrap_hit_flag_next[i];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_data <= read_data_next;
      irq_mask  <= irq_mask_next;
    end
  end

endmodule
